// ===== sv/nnbs_pkg.sv =====
// types and constants shared by the nearest-neighbor bmp scaler
// no dependencies
`default_nettype none

package nnbs_pkg;

    localparam int DIM_W   = 15;
    localparam int IDX_W   = 14;
    localparam int ORG_W   = 16;
    localparam int SCR_W   = 17;
    localparam int OFS_W   = 30;
    localparam int STR_W   = 18;
    localparam int NUM_W   = IDX_W + DIM_W;
    localparam int REM_W   = 30;
    localparam int QUO_W   = DIM_W;
    localparam int PRD_W   = DIM_W + STR_W;
    localparam int OQ_DEPTH = 32;
    localparam int MQ_DEPTH = 4;

    typedef enum logic [2:0] {
        REG_SRC_W     = 3'd0,
        REG_SRC_H     = 3'd1,
        REG_FOUR_BPP  = 3'd2,
        REG_TOP_FIRST = 3'd3,
        REG_TGT_W     = 3'd4,
        REG_TGT_H     = 3'd5,
        REG_ORG_X     = 3'd6,
        REG_ORG_Y     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] tw;
        logic [DIM_W-1:0] th;
        logic             four_bpp;
        logic             top_first;
        logic             scaled;
        logic [STR_W-1:0] stride;
        logic [ORG_W-1:0] org_x;
        logic [ORG_W-1:0] org_y;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [NUM_W-1:0] num_y;
        logic [NUM_W-1:0] num_x;
        logic             clamp_y;
        logic             clamp_x;
        logic             bad;
        logic             alpha;
        logic [SCR_W-1:0] scr_x;
        logic [SCR_W-1:0] scr_y;
    } t_work;

    typedef struct packed {
        logic [OFS_W-1:0] offset;
        logic [SCR_W-1:0] scr_x;
        logic [SCR_W-1:0] scr_y;
        logic             alpha;
        logic             bad;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/nearest_neighbor_bmp_scaler.sv =====
// Nearest-neighbor source addressing for a padded BMP pixel buffer. Each pushed
// word (dest_row, dest_col) yields one result word: source byte offset, screen
// position, alpha source and out-of-range flag. One word per clock is taken
// and delivered while no stall holds the flow; an accepted word passes through
// the input register and middle queue, divider input register, the
// 15-stage restoring divider pipeline, index-select and multiply stages, and
// the result queue write. A 32-word result queue lets the consumer stall
// without losing throughput.
// depends on nnbs_pkg, nnbs_front, nnbs_back
`default_nettype none

module nearest_neighbor_bmp_scaler import nnbs_pkg::*; #(
    parameter int MAX_DIMENSION = 16384
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [IDX_W-1:0]  i_dest_row,
    input  wire logic [IDX_W-1:0]  i_dest_col,
    output logic                   empty,
    input  wire logic              pop,
    output logic      [OFS_W-1:0]  o_source_offset,
    output logic      [SCR_W-1:0]  o_screen_x,
    output logic      [SCR_W-1:0]  o_screen_y,
    output logic                   o_alpha_from_data,
    output logic                   o_out_of_range
);

    localparam int DIM_MAX = (1 << DIM_W) - 1;
    localparam logic [DIM_W-1:0] CAP =
        DIM_W'((MAX_DIMENSION > DIM_MAX) ? DIM_MAX : MAX_DIMENSION);

    logic [DIM_W-1:0] r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic             r_four, r_top;
    logic [ORG_W-1:0] r_org_x, r_org_y;
    logic             w_wr;
    t_reg_idx         w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= DIM_W'(1);
            r_src_h <= DIM_W'(1);
            r_four  <= 1'b0;
            r_top   <= 1'b0;
            r_tgt_w <= '0;
            r_tgt_h <= '0;
            r_org_x <= '0;
            r_org_y <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_SRC_W:     r_src_w <= pwdata[DIM_W-1:0];
                REG_SRC_H:     r_src_h <= pwdata[DIM_W-1:0];
                REG_FOUR_BPP:  r_four  <= pwdata[0];
                REG_TOP_FIRST: r_top   <= pwdata[0];
                REG_TGT_W:     r_tgt_w <= pwdata[DIM_W-1:0];
                REG_TGT_H:     r_tgt_h <= pwdata[DIM_W-1:0];
                REG_ORG_X:     r_org_x <= pwdata[ORG_W-1:0];
                REG_ORG_Y:     r_org_y <= pwdata[ORG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SRC_W:     prdata = 32'(r_src_w);
            REG_SRC_H:     prdata = 32'(r_src_h);
            REG_FOUR_BPP:  prdata = 32'(r_four);
            REG_TOP_FIRST: prdata = 32'(r_top);
            REG_TGT_W:     prdata = 32'(r_tgt_w);
            REG_TGT_H:     prdata = 32'(r_tgt_h);
            REG_ORG_X:     prdata = 32'(r_org_x);
            REG_ORG_Y:     prdata = 32'(r_org_y);
            default:       prdata = '0;
        endcase
    end

    t_cfg            w_cfg;
    logic [STR_W:0]  w_row_bytes;

    always_comb begin
        w_cfg.w         = (r_src_w == '0) ? DIM_W'(1) : (r_src_w > CAP) ? CAP : r_src_w;
        w_cfg.h         = (r_src_h == '0) ? DIM_W'(1) : (r_src_h > CAP) ? CAP : r_src_h;
        w_cfg.tw        = (r_tgt_w > CAP) ? CAP : r_tgt_w;
        w_cfg.th        = (r_tgt_h > CAP) ? CAP : r_tgt_h;
        w_cfg.four_bpp  = r_four;
        w_cfg.top_first = r_top;
        w_cfg.scaled    = (r_tgt_w != '0) && (r_tgt_h != '0);
        w_cfg.org_x     = r_org_x;
        w_cfg.org_y     = r_org_y;
        w_row_bytes     = r_four ? ((STR_W+1)'(w_cfg.w) << 2)
                                 : ((STR_W+1)'(w_cfg.w) << 1) + (STR_W+1)'(w_cfg.w);
        w_row_bytes     = w_row_bytes + (STR_W+1)'(3);
        w_cfg.stride    = {w_row_bytes[STR_W-1:2], 2'b00};
    end

    t_work   w_work;
    logic    w_mid_empty, w_take;
    t_result w_res;

    nnbs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_push  (push),
        .i_row   (i_dest_row),
        .i_col   (i_dest_col),
        .o_full  (full),
        .i_take  (w_take),
        .o_work  (w_work),
        .o_empty (w_mid_empty)
    );

    nnbs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_work   (w_work),
        .i_avail  (!w_mid_empty),
        .o_take   (w_take),
        .i_pop    (pop),
        .o_result (w_res),
        .o_empty  (empty)
    );

    assign o_source_offset   = w_res.offset;
    assign o_screen_x        = w_res.scr_x;
    assign o_screen_y        = w_res.scr_y;
    assign o_alpha_from_data = w_res.alpha;
    assign o_out_of_range    = w_res.bad;

endmodule

`default_nettype wire

// ===== sv/nnbs_fifo.sv =====
// small flop-based word queue with count
// depends on nothing
`default_nettype none

module nnbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count past depth");

endmodule

`default_nettype wire

// ===== sv/nnbs_front.sv =====
// front end: accepts coordinates, classifies mode and range, forms dividends
// depends on nnbs_pkg, nnbs_fifo
`default_nettype none

module nnbs_front import nnbs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_push,
    input  wire logic [IDX_W-1:0] i_row,
    input  wire logic [IDX_W-1:0] i_col,
    output logic                  o_full,
    input  wire logic             i_take,
    output t_work                 o_work,
    output logic                  o_empty
);

    logic  r_v, n_v;
    t_work r_item, n_item;
    logic  w_q_full, w_accept, w_move;

    assign o_full   = r_v && w_q_full;
    assign w_accept = i_push && !o_full;
    assign w_move   = r_v && !w_q_full;
    assign n_v      = w_accept || (r_v && !w_move);

    always_comb begin
        n_item         = r_item;
        n_item.row     = i_row;
        n_item.col     = i_col;
        n_item.num_y   = NUM_W'(i_row) * NUM_W'(i_cfg.h);
        n_item.num_x   = NUM_W'(i_col) * NUM_W'(i_cfg.w);
        n_item.clamp_y = DIM_W'(i_row) >= i_cfg.th;
        n_item.clamp_x = DIM_W'(i_col) >= i_cfg.tw;
        n_item.bad     = !i_cfg.scaled &&
                         ((DIM_W'(i_row) >= i_cfg.h) || (DIM_W'(i_col) >= i_cfg.w));
        n_item.alpha   = i_cfg.four_bpp;
        n_item.scr_x   = {i_cfg.org_x[ORG_W-1], i_cfg.org_x} + SCR_W'(i_col);
        n_item.scr_y   = {i_cfg.org_y[ORG_W-1], i_cfg.org_y} + SCR_W'(i_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    logic [$bits(t_work)-1:0] w_q_out;

    nnbs_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (MQ_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_move),
        .i_data  (r_item),
        .i_pop   (i_take),
        .o_data  (w_q_out),
        .o_full  (w_q_full),
        .o_empty (o_empty)
    );

    assign o_work = t_work'(w_q_out);

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && w_q_full) |=> r_v)
        else $error("front word lost while stalled");

endmodule

`default_nettype wire

// ===== sv/nnbs_back.sv =====
// back end: pipelined restoring dividers, row flip, offset multiply, result queue
// depends on nnbs_pkg, nnbs_fifo
`default_nettype none

module nnbs_back import nnbs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_work i_work,
    input  wire logic  i_avail,
    output logic       o_take,
    input  wire logic  i_pop,
    output t_result    o_result,
    output logic       o_empty
);

    localparam int CW = $clog2(OQ_DEPTH + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_out_pop, w_out_full;

    assign o_take    = i_avail && (r_cnt < CW'(OQ_DEPTH));
    assign w_out_pop = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (o_take && !w_out_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_out_pop && !o_take) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // divider pipeline, one quotient bit per stage
    logic             r_vld [QUO_W+1];
    t_work            r_it  [QUO_W+1];
    logic [REM_W-1:0] r_ry  [QUO_W+1];
    logic [REM_W-1:0] r_rx  [QUO_W+1];
    logic [QUO_W-1:0] r_qy  [QUO_W+1];
    logic [QUO_W-1:0] r_qx  [QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_vld[0] <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_vld[0] <= o_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it[0] <= i_work;
        r_ry[0] <= REM_W'(i_work.num_y);
        r_rx[0] <= REM_W'(i_work.num_x);
        r_qy[0] <= '0;
        r_qx[0] <= '0;
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_div
        localparam int B = QUO_W - 1 - s;
        logic [REM_W-1:0] w_dy, w_dx;
        logic             w_ge_y, w_ge_x;

        assign w_dy   = REM_W'(i_cfg.th) << B;
        assign w_dx   = REM_W'(i_cfg.tw) << B;
        assign w_ge_y = r_ry[s] >= w_dy;
        assign w_ge_x = r_rx[s] >= w_dx;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_it[s+1] <= r_it[s];
            r_ry[s+1] <= w_ge_y ? r_ry[s] - w_dy : r_ry[s];
            r_rx[s+1] <= w_ge_x ? r_rx[s] - w_dx : r_rx[s];
            r_qy[s+1] <= r_qy[s] | (QUO_W'(w_ge_y) << B);
            r_qx[s+1] <= r_qx[s] | (QUO_W'(w_ge_x) << B);
        end
    end

    // index select and row flip
    t_work            r_a_it;
    logic             r_a_vld;
    logic [DIM_W-1:0] r_a_srow, r_a_sx;
    logic [DIM_W-1:0] w_sy, w_sx, w_hm1, w_wm1;
    t_work            w_e;

    assign w_e   = r_it[QUO_W];
    assign w_hm1 = i_cfg.h - 1'b1;
    assign w_wm1 = i_cfg.w - 1'b1;

    always_comb begin
        if (!i_cfg.scaled) begin
            w_sy = DIM_W'(w_e.row);
            w_sx = DIM_W'(w_e.col);
        end else begin
            w_sy = w_e.clamp_y ? w_hm1 : r_qy[QUO_W];
            w_sx = w_e.clamp_x ? w_wm1 : r_qx[QUO_W];
        end
    end

    // products
    t_work            r_b_it;
    logic             r_b_vld;
    logic [PRD_W-1:0] r_b_prod;
    logic [STR_W-1:0] r_b_xb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= r_vld[QUO_W];
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_it   <= w_e;
        r_a_srow <= i_cfg.top_first ? w_sy : w_hm1 - w_sy;
        r_a_sx   <= w_sx;
        r_b_it   <= r_a_it;
        r_b_prod <= PRD_W'(r_a_srow) * PRD_W'(i_cfg.stride);
        r_b_xb   <= i_cfg.four_bpp ? (STR_W'(r_a_sx) << 2)
                                   : (STR_W'(r_a_sx) << 1) + STR_W'(r_a_sx);
    end

    t_result                    w_res;
    logic [PRD_W-1:0]           w_sum;
    logic [$bits(t_result)-1:0] w_q_out;

    assign w_sum        = r_b_prod + PRD_W'(r_b_xb);
    assign w_res.offset = r_b_it.bad ? '0 : w_sum[OFS_W-1:0];
    assign w_res.scr_x  = r_b_it.scr_x;
    assign w_res.scr_y  = r_b_it.scr_y;
    assign w_res.alpha  = r_b_it.alpha;
    assign w_res.bad    = r_b_it.bad;

    nnbs_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_b_vld),
        .i_data  (w_res),
        .i_pop   (i_pop),
        .o_data  (w_q_out),
        .o_full  (w_out_full),
        .o_empty (o_empty)
    );

    assign o_result = t_result'(w_q_out);

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(OQ_DEPTH))
        else $error("credit count past queue depth");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> !w_out_full)
        else $error("result word arrives at full queue");

    a_empty_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> o_empty)
        else $error("result queue holds words without credit");

endmodule

`default_nettype wire

// ===== verif/tb_nearest_neighbor_bmp_scaler.sv =====
// testbench for nearest_neighbor_bmp_scaler: directed table then random phases,
// each result checked against a directed table entry or a local address predictor and screen-position model
// depends on nnbs_pkg and nearest_neighbor_bmp_scaler
`timescale 1ns / 1ps

module tb_nearest_neighbor_bmp_scaler;
    import nnbs_pkg::*;

    localparam int MAX_DIM   = 16384;
    localparam int NUM_RAND  = 10;
    localparam int RAND_ITEMS = 75;

    typedef struct {
        int      phase;
        int      row;
        int      col;
        bit      typed;
        t_result exp;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [4:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    logic             push;
    logic             full;
    logic [IDX_W-1:0] i_dest_row;
    logic [IDX_W-1:0] i_dest_col;
    logic             empty;
    logic             pop;
    logic [OFS_W-1:0] o_source_offset;
    logic [SCR_W-1:0] o_screen_x;
    logic [SCR_W-1:0] o_screen_y;
    logic             o_alpha_from_data;
    logic             o_out_of_range;

    logic [31:0] cfg_regs [8];
    t_result     pending_pixels [$];
    int          errors;
    bit          quiet;
    bit          stall_req;
    t_dir_row    dir_table [$];

    nearest_neighbor_bmp_scaler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .i_dest_row(i_dest_row), .i_dest_col(i_dest_col),
        .empty(empty), .pop(pop),
        .o_source_offset(o_source_offset), .o_screen_x(o_screen_x),
        .o_screen_y(o_screen_y), .o_alpha_from_data(o_alpha_from_data),
        .o_out_of_range(o_out_of_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("tb_nearest_neighbor_bmp_scaler failed");
        $finish;
    end

    function automatic longint cap_dim(longint v, longint lo);
        if (v < lo) v = lo;
        if (v > MAX_DIM) v = MAX_DIM;
        return v;
    endfunction

    function automatic t_result predict_pixel(int row, int col);
        t_result r;
        longint w, h, bpp, stride, tw, th, sx, sy, srow;
        w = cap_dim(cfg_regs[REG_SRC_W] & 32'h7fff, 1);
        h = cap_dim(cfg_regs[REG_SRC_H] & 32'h7fff, 1);
        bpp = cfg_regs[REG_FOUR_BPP][0] ? 4 : 3;
        stride = (w * bpp + 3) & ~longint'(3);
        tw = cap_dim(cfg_regs[REG_TGT_W] & 32'h7fff, 0);
        th = cap_dim(cfg_regs[REG_TGT_H] & 32'h7fff, 0);
        r.bad = 1'b0;
        r.offset = '0;
        if (tw != 0 && th != 0) begin
            sy = (row * h) / th;
            sx = (col * w) / tw;
            if (sy >= h) sy = h - 1;
            if (sx >= w) sx = w - 1;
        end else begin
            sy = row;
            sx = col;
            if (sy >= h || sx >= w) r.bad = 1'b1;
        end
        if (!r.bad) begin
            srow = cfg_regs[REG_TOP_FIRST][0] ? sy : (h - 1 - sy);
            r.offset = OFS_W'(srow * stride + sx * bpp);
        end
        r.scr_x = SCR_W'(longint'($signed(cfg_regs[REG_ORG_X][15:0])) + col);
        r.scr_y = SCR_W'(longint'($signed(cfg_regs[REG_ORG_Y][15:0])) + row);
        r.alpha = cfg_regs[REG_FOUR_BPP][0];
        return r;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_regs[idx] = value;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(int row, int col, bit typed, t_result exp);
        push       <= 1'b1;
        i_dest_row <= IDX_W'(row);
        i_dest_col <= IDX_W'(col);
        do @(posedge i_clk); while (full);
        pending_pixels.push_back(typed ? exp : predict_pixel(row, col));
        if (!quiet && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic int rand_dim();
        if ($urandom_range(0, 9) < 7) return $urandom_range(1, 64);
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 0 : 32767;
        return $urandom_range(0, 32767);
    endfunction

    function automatic int rand_index(int lim);
        int v;
        if ($urandom_range(0, 9) < 6) begin
            v = $urandom_range(0, 2 * lim + 1);
            return v > 16383 ? 16383 : v;
        end
        return $urandom_range(0, 16383);
    endfunction

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected word offset=%0d", $time, o_source_offset);
                errors++;
            end else begin
                e = pending_pixels.pop_front();
                if (o_source_offset !== e.offset) begin
                    $display("%0t: source_offset exp %0d got %0d", $time, e.offset,
                             o_source_offset);
                    errors++;
                end
                if (o_screen_x !== e.scr_x) begin
                    $display("%0t: screen_x exp %0h got %0h", $time, e.scr_x, o_screen_x);
                    errors++;
                end
                if (o_screen_y !== e.scr_y) begin
                    $display("%0t: screen_y exp %0h got %0h", $time, e.scr_y, o_screen_y);
                    errors++;
                end
                if (o_alpha_from_data !== e.alpha) begin
                    $display("%0t: alpha_from_data exp %0b got %0b", $time, e.alpha,
                             o_alpha_from_data);
                    errors++;
                end
                if (o_out_of_range !== e.bad) begin
                    $display("%0t: out_of_range exp %0b got %0b", $time, e.bad,
                             o_out_of_range);
                    errors++;
                end
            end
        end
    end

    initial begin
        pop = 1'b0;
        @(posedge i_clk);
        wait (i_rst_n);
        forever begin
            if (stall_req) begin
                pop <= 1'b0;
                repeat (200) @(posedge i_clk);
                stall_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        t_result none;
        int sw, sh;
        errors    = 0;
        quiet     = 1'b0;
        stall_req = 1'b0;
        none      = '0;
        i_rst_n   = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        push = 1'b0; i_dest_row = '0; i_dest_col = '0;
        cfg_regs = '{32'd1, 32'd1, 0, 0, 0, 0, 0, 0};

        // 1x1 image after reset, 1:1 mode
        dir_table.push_back('{0, 0, 0, 1, '{offset: 0, scr_x: 0, scr_y: 0,
                               alpha: 0, bad: 0}});
        dir_table.push_back('{0, 1, 0, 1, '{offset: 0, scr_x: 0, scr_y: 1,
                               alpha: 0, bad: 1}});
        dir_table.push_back('{0, 0, 1, 1, '{offset: 0, scr_x: 1, scr_y: 0,
                               alpha: 0, bad: 1}});
        dir_table.push_back('{0, 16383, 16383, 1, '{offset: 0, scr_x: 16383,
                               scr_y: 16383, alpha: 0, bad: 1}});
        // largest image, 32-bit bottom-up, origin extremes
        dir_table.push_back('{1, 0, 0, 1, '{offset: 30'd1073676288, scr_x: 17'd32767,
                               scr_y: 17'h18000, alpha: 1, bad: 0}});
        dir_table.push_back('{1, 16383, 16383, 1, '{offset: 30'd65532,
                               scr_x: 17'd49150, scr_y: 17'(-16385), alpha: 1, bad: 0}});
        dir_table.push_back('{1, 8191, 1, 0, none});
        // scaled, zero and oversized source sizes, target index past target size
        dir_table.push_back('{2, 0, 0, 0, none});
        dir_table.push_back('{2, 4, 2, 0, none});
        dir_table.push_back('{2, 16383, 0, 0, none});
        dir_table.push_back('{2, 2, 16383, 0, none});
        dir_table.push_back('{2, 5, 3, 0, none});
        dir_table.push_back('{2, 9000, 9000, 0, none});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 3 + NUM_RAND; ph++) begin
            if (ph == 1) begin
                write_reg(REG_SRC_W, 32'd16384);
                write_reg(REG_SRC_H, 32'd16384);
                write_reg(REG_FOUR_BPP, 32'd1);
                write_reg(REG_TOP_FIRST, 32'd0);
                write_reg(REG_TGT_W, 32'd0);
                write_reg(REG_TGT_H, 32'd0);
                write_reg(REG_ORG_X, 32'h7fff);
                write_reg(REG_ORG_Y, 32'h8000);
            end else if (ph == 2) begin
                write_reg(REG_SRC_W, 32'd0);
                write_reg(REG_SRC_H, 32'h7fff);
                write_reg(REG_FOUR_BPP, 32'd0);
                write_reg(REG_TOP_FIRST, 32'd1);
                write_reg(REG_TGT_W, 32'd3);
                write_reg(REG_TGT_H, 32'd5);
                write_reg(REG_ORG_X, 32'h8000);
                write_reg(REG_ORG_Y, 32'h7fff);
            end else if (ph > 2) begin
                sw = rand_dim();
                sh = rand_dim();
                write_reg(REG_SRC_W, sw);
                write_reg(REG_SRC_H, sh);
                write_reg(REG_FOUR_BPP, $urandom_range(0, 1));
                write_reg(REG_TOP_FIRST, $urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0: begin
                        write_reg(REG_TGT_W, 0);
                        write_reg(REG_TGT_H, 0);
                    end
                    1: begin
                        write_reg(REG_TGT_W, $urandom_range(0, 1) ? 0 : rand_dim());
                        write_reg(REG_TGT_H, 0);
                    end
                    default: begin
                        write_reg(REG_TGT_W, $urandom_range(1, 64));
                        write_reg(REG_TGT_H, $urandom_range(1, 64));
                    end
                endcase
                write_reg(REG_ORG_X, $urandom_range(0, 65535));
                write_reg(REG_ORG_Y, $urandom_range(0, 65535));
            end
            quiet = (ph == 2 + NUM_RAND);
            if (ph == 4) stall_req = 1'b1;
            if (ph < 3) begin
                foreach (dir_table[k])
                    if (dir_table[k].phase == ph)
                        send_pixel(dir_table[k].row, dir_table[k].col, dir_table[k].typed,
                                   dir_table[k].exp);
            end else begin
                for (int n = 0; n < RAND_ITEMS; n++) begin
                    if (ph == 4 && n < 60) begin
                        push       <= 1'b1;
                        i_dest_row <= IDX_W'(rand_index(sh));
                        i_dest_col <= IDX_W'(rand_index(sw));
                        do @(posedge i_clk); while (full);
                        pending_pixels.push_back(predict_pixel(i_dest_row, i_dest_col));
                    end else begin
                        send_pixel(rand_index(sh), rand_index(sw), 1'b0, none);
                    end
                end
            end
            drain();
        end

        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("tb_nearest_neighbor_bmp_scaler passed");
        end else begin
            $display("tb_nearest_neighbor_bmp_scaler failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/nnbs_pkg.sv
sv/nnbs_fifo.sv
sv/nnbs_front.sv
sv/nnbs_back.sv
sv/nearest_neighbor_bmp_scaler.sv
verif/tb_nearest_neighbor_bmp_scaler.sv
